FILE: rtl/shuffled_lcg_uniform_generator_unit_macros.svh
// assertion helpers, sampled on clk and held off while rst_n is low
`ifndef SHUFFLED_LCG_UNIFORM_GENERATOR_UNIT_MACROS_SVH
`define SHUFFLED_LCG_UNIFORM_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define SLCG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/slcg_pkg.sv
`timescale 1ns / 1ps

package slcg_pkg;

    localparam int TABLE_DEPTH  = 32;
    localparam int DATA_W       = 31;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int WARMUP_STEPS = TABLE_DEPTH + 8;
    localparam int CNT_W        = $clog2(WARMUP_STEPS);
    localparam int MUL_W        = 15;
    localparam int PROD_W       = DATA_W + MUL_W;

    localparam logic [MUL_W-1:0]  LCG_MUL = 15'd16807;
    localparam logic [DATA_W-1:0] LCG_MOD = 31'h7FFF_FFFF;

    // slot divisor, a power of two for power-of-two table depths
    localparam longint PICK_DIV   = 1 + (longint'(2147483646) / longint'(TABLE_DEPTH));
    localparam int     PICK_SHIFT = $clog2(PICK_DIV);

    typedef struct packed {
        logic             seed_load;
        logic             seed_from_input;
        logic             lcg_step;
        logic             ram_we;
        logic             addr_from_cnt;
        logic [IDX_W-1:0] seed_idx;
        logic             pick_from_lcg;
        logic             result_load;
    } slcg_cmd_t;

    typedef struct packed {
        logic need_seed;
    } slcg_status_t;

    // x * 16807 mod (2^31 - 1) by end-around carry
    function automatic logic [DATA_W-1:0] lcg_next(input logic [DATA_W-1:0] x);
        logic [PROD_W-1:0] prod;
        logic [DATA_W:0]   fold;
        prod = PROD_W'(x) * PROD_W'(LCG_MUL);
        fold = {1'b0, prod[DATA_W-1:0]} + (DATA_W + 1)'(prod[PROD_W-1:DATA_W]);
        if (fold >= (DATA_W + 1)'(LCG_MOD))
        begin
            fold = fold - (DATA_W + 1)'(LCG_MOD);
        end
        lcg_next = fold[DATA_W-1:0];
    endfunction

    // seed reduced modulo the modulus, zero taken as one
    function automatic logic [DATA_W-1:0] seed_map(input logic [DATA_W-1:0] s);
        if ((s == '0) || (s == LCG_MOD))
        begin
            seed_map = DATA_W'(1);
        end
        else
        begin
            seed_map = s;
        end
    endfunction

    function automatic logic [IDX_W-1:0] pick_slot(input logic [DATA_W-1:0] pick);
        logic [DATA_W-1:0] q;
        q = pick >> PICK_SHIFT;
        if (q >= DATA_W'(TABLE_DEPTH))
        begin
            pick_slot = IDX_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            pick_slot = q[IDX_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/slcg_ram.sv
`timescale 1ns / 1ps

module slcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/slcg_datapath.sv
`timescale 1ns / 1ps

module slcg_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  slcg_pkg::slcg_cmd_t              cmd,
    output slcg_pkg::slcg_status_t           status,
    input  logic [slcg_pkg::DATA_W-1:0]      seed_value,
    output logic [slcg_pkg::DATA_W-1:0]      sample
);

    logic [slcg_pkg::DATA_W-1:0] lcg_value_reg;
    logic [slcg_pkg::DATA_W-1:0] last_pick_reg;
    logic [slcg_pkg::DATA_W-1:0] sample_reg;
    logic [slcg_pkg::DATA_W-1:0] lcg_value_next;
    logic [slcg_pkg::DATA_W-1:0] seed_src;
    logic [slcg_pkg::IDX_W-1:0]  ram_addr;
    logic [slcg_pkg::DATA_W-1:0] ram_wdata;
    logic [slcg_pkg::DATA_W-1:0] ram_rdata;

    assign lcg_value_next = slcg_pkg::lcg_next(lcg_value_reg);
    assign seed_src       = cmd.seed_from_input ? seed_value : lcg_value_reg;

    assign ram_addr  = cmd.addr_from_cnt ? cmd.seed_idx : slcg_pkg::pick_slot(last_pick_reg);
    assign ram_wdata = cmd.addr_from_cnt ? lcg_value_next : lcg_value_reg;

    slcg_ram #(
        .WIDTH (slcg_pkg::DATA_W),
        .DEPTH (slcg_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_value_reg <= '0;
            last_pick_reg <= '0;
        end
        else
        begin
            if (cmd.seed_load)
            begin
                lcg_value_reg <= slcg_pkg::seed_map(seed_src);
            end
            else if (cmd.lcg_step)
            begin
                lcg_value_reg <= lcg_value_next;
            end

            if (cmd.pick_from_lcg)
            begin
                last_pick_reg <= lcg_value_next;
            end
            else if (cmd.result_load)
            begin
                last_pick_reg <= ram_rdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            sample_reg <= ram_rdata;
        end
    end

    assign status.need_seed = (last_pick_reg == '0);
    assign sample           = sample_reg;

endmodule

FILE: rtl/slcg_ctrl.sv
`timescale 1ns / 1ps
`include "shuffled_lcg_uniform_generator_unit_macros.svh"

module slcg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   mode,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  slcg_pkg::slcg_status_t status,
    output slcg_pkg::slcg_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_READ,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic                       s_tready_reg;
    logic                       m_tvalid_reg;
    logic [slcg_pkg::CNT_W-1:0] cnt_reg;
    logic                       accept;
    logic                       out_free;
    logic                       do_seed;

    assign accept   = s_tvalid && s_tready_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign do_seed  = mode || status.need_seed;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.seed_load       = accept && do_seed;
                cmd.seed_from_input = mode;
            end
            ST_SEED:
            begin
                cmd.lcg_step      = 1'b1;
                cmd.addr_from_cnt = 1'b1;
                cmd.seed_idx      = cnt_reg[slcg_pkg::IDX_W-1:0];
                cmd.ram_we        = (cnt_reg < slcg_pkg::CNT_W'(slcg_pkg::TABLE_DEPTH));
                cmd.pick_from_lcg = (cnt_reg == '0);
            end
            ST_READ:
            begin
                cmd.lcg_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.ram_we      = out_free;
                cmd.result_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cmd.result_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        s_tready_reg <= 1'b0;
                        if (do_seed)
                        begin
                            state_reg <= ST_SEED;
                            cnt_reg   <= slcg_pkg::CNT_W'(slcg_pkg::WARMUP_STEPS - 1);
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_SEED:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= ST_IDLE;
                    s_tready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    `SLCG_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second transfer taken while busy")
    `SLCG_ASSERT_NOW(a_ready_idle, s_tready, state_reg == ST_IDLE, "ready outside idle")
    `SLCG_ASSERT_NEXT(a_seed_exit, (state_reg == ST_SEED) && (cnt_reg == '0), state_reg == ST_READ, "warm-up did not end in table read")
    `SLCG_ASSERT_NEXT(a_result_shown, cmd.result_load, m_tvalid, "loaded result not presented")

endmodule

FILE: rtl/shuffled_lcg_uniform_generator_unit.sv
`timescale 1ns / 1ps
// shuffled minimal-standard uniform generator
// input transfer (s_tvalid/s_tready): s_tuser is the mode, 0 draw, 1 reseed then draw;
// s_tdata carries the seed on a reseed and is ignored on a draw.
// output transfer (m_tvalid/m_tready): m_tdata carries one sample in 1 .. 2^31-2,
// the uniform fraction being sample / (2^31 - 1).
// every input transfer gives exactly one output transfer.
// a draw takes one generator step with the registered table read, then loads the output
// register, which raises m_tvalid; the next draw is taken only once that result is loaded.
// a reseed first runs warm-up generator steps, one per cycle through the single table port,
// then keeps stepping while writing each entry of the 32-entry shuffle table in turn.
// one item is in flight at a time; s_tready returns when the result is loaded.
// after reset the generator is unseeded: the first draw seeds from 1.
// reset does not clear the table; seeding always fills it before it is read.
// if the receiver stalls, the result waits in the output register and the next
// item is accepted; its result waits in the block until the register frees.

module shuffled_lcg_uniform_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] seed_value, [31] zero
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] sample, [31] zero
);

    slcg_pkg::slcg_cmd_t          cmd;
    slcg_pkg::slcg_status_t       status;
    logic [slcg_pkg::DATA_W-1:0]  sample;

    slcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    slcg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .seed_value (s_tdata[slcg_pkg::DATA_W-1:0]),
        .sample     (sample)
    );

    assign m_tdata = {1'b0, sample};

endmodule
